// File: hdl/hbade_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbade_pkg
// Shared types, byte codes and helper functions of the half-block encoder.
// ----------------------------------------------------------------------------
package hbade_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_COLUMNS   = 2'd1;
    localparam logic [1:0] CFG_ROWS      = 2'd2;

    // output byte codes
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] GLYPH_B0  = 8'hE2;
    localparam logic [7:0] GLYPH_B1  = 8'h96;
    localparam logic [7:0] GLYPH_B2  = 8'h84;

    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    typedef struct packed {
        logic        emit_cur;
        logic        emit_bg;
        logic        emit_fg;
        logic        glyph;
        logic        nl;
        logic        fend;
        logic [9:0]  row_p1;
        logic [9:0]  col_p1;
        logic [23:0] top;
        logic [23:0] bot;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_front_stat;

    // squared RGB distance above threshold squared
    function automatic logic f_differs(input logic [23:0] a, input logic [23:0] b,
                                       input logic [15:0] thr_sq);
        logic [7:0]  d0, d1, d2;
        logic [17:0] sum;
        d0  = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
        d1  = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
        d2  = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
        sum = 18'(16'(d0) * 16'(d0)) + 18'(16'(d1) * 16'(d1))
            + 18'(16'(d2) * 16'(d2));
        return sum > 18'(thr_sq);
    endfunction

    // three decimal digits of a value below 1000, reciprocal multiply
    function automatic logic [11:0] f_bcd(input logic [9:0] v);
        logic [16:0] p;
        logic [3:0]  h, t, o;
        logic [9:0]  r;
        logic [13:0] q;
        p = 17'(v) * 17'd41;
        h = p[15:12];
        r = v - 10'(h) * 10'd100;
        q = 14'(r) * 14'd103;
        t = q[13:10];
        o = 4'(r - 10'(t) * 10'd10);
        return {h, t, o};
    endfunction

endpackage

// File: hdl/hbade_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbade_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module hbade_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hdl/hbade_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbade_front
// Track position, compare against the shown frame, build byte commands.
// ----------------------------------------------------------------------------
module hbade_front
    import hbade_pkg::*;
#(
    parameter int MAX_COLUMNS   = 256,
    parameter int MAX_CHAR_ROWS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [23:0] i_top,
    input  logic [23:0] i_bot,
    input  logic [15:0] i_thr_sq,
    input  logic [8:0]  i_cols,
    input  logic [7:0]  i_rows,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    output t_front_stat o_stat
);
    localparam int DEPTH = MAX_COLUMNS * MAX_CHAR_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CPW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RPW   = (MAX_CHAR_ROWS > 1) ? $clog2(MAX_CHAR_ROWS) : 1;

    logic [CPW-1:0] r_col;
    logic [RPW-1:0] r_row;
    logic [23:0]    r_cur_bg, r_cur_fg;
    logic           r_cmn, r_any;
    logic           r_clearing;
    logic [AW-1:0]  r_clr_addr;

    logic           r_b_valid, r_b_lc, r_b_lr;
    logic [23:0]    r_b_top, r_b_bot;
    logic [AW-1:0]  r_b_idx;
    logic [9:0]     r_b_row_p1, r_b_col_p1;
    logic           r_byp;
    logic [47:0]    r_byp_data;

    logic [9:0]     cols_eff, rows_eff, col_p1, row_p1;
    logic           last_col, last_row;
    logic [AW-1:0]  idx;
    logic [47:0]    rdata, old, wdata;
    logic           changed, emit_cur, emit_bg, emit_fg, cmn_after, any_after;
    logic           nl, fend, frame_done;
    logic [23:0]    new_bg, new_fg;
    logic           we;
    logic [AW-1:0]  waddr;

    always_comb begin
        cols_eff = {1'b0, i_cols};
        if (cols_eff == 10'd0) begin
            cols_eff = 10'd1;
        end else if (cols_eff > 10'(MAX_COLUMNS)) begin
            cols_eff = 10'(MAX_COLUMNS);
        end
        rows_eff = {2'b0, i_rows};
        if (rows_eff == 10'd0) begin
            rows_eff = 10'd1;
        end else if (rows_eff > 10'(MAX_CHAR_ROWS)) begin
            rows_eff = 10'(MAX_CHAR_ROWS);
        end
    end

    assign col_p1   = 10'(r_col) + 10'd1;
    assign row_p1   = 10'(r_row) + 10'd1;
    assign last_col = col_p1 >= cols_eff;
    assign last_row = row_p1 >= rows_eff;
    assign idx      = AW'(r_row) * AW'(MAX_COLUMNS) + AW'(r_col);

    assign old = r_byp ? r_byp_data : rdata;

    always_comb begin
        changed   = r_b_valid && (f_differs(r_b_top, old[47:24], i_thr_sq)
                    || f_differs(r_b_bot, old[23:0], i_thr_sq));
        emit_cur  = changed && r_cmn;
        emit_bg   = changed && f_differs(r_b_top, r_cur_bg, i_thr_sq);
        emit_fg   = changed && f_differs(r_b_bot, r_cur_fg, i_thr_sq);
        new_bg    = emit_bg ? r_b_top : r_cur_bg;
        new_fg    = emit_fg ? r_b_bot : r_cur_fg;
        cmn_after = changed ? 1'b0 : (r_b_valid ? 1'b1 : r_cmn);
        any_after = r_any | emit_cur;
        frame_done = r_b_valid && r_b_lc && r_b_lr;
        fend      = frame_done && any_after;
        nl        = fend || (r_b_valid && r_b_lc && !r_b_lr && !cmn_after);
    end

    always_comb begin
        o_cmd.emit_cur = emit_cur;
        o_cmd.emit_bg  = emit_bg;
        o_cmd.emit_fg  = emit_fg;
        o_cmd.glyph    = changed;
        o_cmd.nl       = nl;
        o_cmd.fend     = fend;
        o_cmd.row_p1   = r_b_row_p1;
        o_cmd.col_p1   = r_b_col_p1;
        o_cmd.top      = r_b_top;
        o_cmd.bot      = r_b_bot;
    end
    assign o_cmd_valid     = changed || nl;
    assign o_stat.clearing = r_clearing;
    assign o_stat.busy     = r_b_valid;

    // clearing sweep owns the write port after reset
    assign we    = r_clearing || changed;
    assign waddr = r_clearing ? r_clr_addr : r_b_idx;
    assign wdata = r_clearing ? 48'd0 : {new_bg, new_fg};

    hbade_ram #(.WIDTH(48), .DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (idx),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        r_b_top    <= i_top;
        r_b_bot    <= i_bot;
        r_b_idx    <= idx;
        r_b_lc     <= last_col;
        r_b_lr     <= last_row;
        r_b_row_p1 <= row_p1;
        r_b_col_p1 <= col_p1;
        r_byp      <= changed && (r_b_idx == idx);
        r_byp_data <= {new_bg, new_fg};
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_cur_bg   <= '0;
            r_cur_fg   <= '0;
            r_cmn      <= 1'b1;
            r_any      <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_b_valid <= i_accept;
            if (r_clearing) begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_accept) begin
                if (last_col && last_row) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + RPW'(1);
                end else begin
                    r_col <= r_col + CPW'(1);
                end
            end
            if (frame_done) begin
                r_cur_bg <= '0;
                r_cur_fg <= '0;
                r_cmn    <= 1'b1;
                r_any    <= 1'b0;
            end else begin
                r_cur_bg <= new_bg;
                r_cur_fg <= new_fg;
                r_cmn    <= cmn_after;
                r_any    <= any_after;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_cmd_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_cmd_valid)
        else $error("command issued during store clearing");
    a_glyph_when_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_bg || emit_fg || emit_cur) |-> changed)
        else $error("escape without changed pair");
`endif
endmodule

// File: hdl/hbade_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbade_cmd_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module hbade_cmd_fifo
    import hbade_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  t_cmd                 i_wdata,
    input  logic                 i_rd,
    output t_cmd                 o_rdata,
    output logic                 o_empty,
    output logic [CMD_CNT_W-1:0] o_count
);
    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wptr, r_rptr;
    logic [CMD_CNT_W-1:0] r_count;

    assign o_rdata = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + CMD_PTR_W'(1);
            end
            if (i_rd) begin
                r_rptr <= r_rptr + CMD_PTR_W'(1);
            end
            r_count <= r_count + CMD_CNT_W'(i_wr) - CMD_CNT_W'(i_rd);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_count < CMD_CNT_W'(CMD_DEPTH)))
        else $error("command queue overflow");
`endif
endmodule

// File: hdl/hbade_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbade_back
// Expand commands into the terminal byte stream, one byte a cycle on pop.
// ----------------------------------------------------------------------------
module hbade_back
    import hbade_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_empty,
    input  t_cmd       i_cmd,
    output logic       o_cmd_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_text_byte,
    output logic       o_last_of_item,
    output logic       o_frame_end
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_DIG   = 3'd2;
    localparam logic [2:0] ST_SEP   = 3'd3;
    localparam logic [2:0] ST_GLYPH = 3'd4;
    localparam logic [2:0] ST_NL    = 3'd5;

    localparam logic [1:0] PH_CUR = 2'd0;
    localparam logic [1:0] PH_BG  = 2'd1;
    localparam logic [1:0] PH_FG  = 2'd2;
    localparam logic [1:0] PH_GLY = 2'd3;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [2:0] r_k, n_k;
    logic [1:0] r_vi, n_vi;
    logic [1:0] r_dig, n_dig;
    t_cmd       r_cmd, n_cmd;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last, r_out_fend;

    logic       adv, bvalid, blast, bfend;
    logic [7:0] bbyte;
    logic [11:0] cur_bcd, nxt_bcd;
    logic [3:0] digit;
    logic [2:0] pre_last;
    logic [1:0] last_vi;

    // first emitting part at or after phase from
    function automatic logic [4:0] f_start(input t_cmd c, input logic [1:0] from);
        logic [4:0] res;
        if (from == PH_CUR && c.emit_cur) begin
            res = {ST_PRE, PH_CUR};
        end else if (from <= PH_BG && c.emit_bg) begin
            res = {ST_PRE, PH_BG};
        end else if (from <= PH_FG && c.emit_fg) begin
            res = {ST_PRE, PH_FG};
        end else if (c.glyph) begin
            res = {ST_GLYPH, PH_GLY};
        end else if (c.nl) begin
            res = {ST_NL, PH_GLY};
        end else begin
            res = {ST_IDLE, PH_CUR};
        end
        return res;
    endfunction

    function automatic logic [9:0] f_val(input t_cmd c, input logic [1:0] ph,
                                         input logic [1:0] vi);
        logic [23:0] col;
        logic [9:0]  res;
        col = (ph == PH_BG) ? c.top : c.bot;
        if (ph == PH_CUR) begin
            res = (vi == 2'd0) ? c.row_p1 : c.col_p1;
        end else begin
            case (vi)
                2'd0:    res = {2'b0, col[23:16]};
                2'd1:    res = {2'b0, col[15:8]};
                default: res = {2'b0, col[7:0]};
            endcase
        end
        return res;
    endfunction

    function automatic logic [1:0] f_ndig(input logic [11:0] b);
        return (b[11:8] != 4'd0) ? 2'd2 : ((b[7:4] != 4'd0) ? 2'd1 : 2'd0);
    endfunction

    assign adv      = !r_out_valid || i_pop;
    assign cur_bcd  = f_bcd(f_val(r_cmd, r_phase, r_vi));
    assign nxt_bcd  = f_bcd(f_val(r_cmd, r_phase, r_vi + 2'd1));
    assign pre_last = (r_phase == PH_CUR) ? 3'd1 : 3'd6;
    assign last_vi  = (r_phase == PH_CUR) ? 2'd1 : 2'd2;

    always_comb begin
        case (r_dig)
            2'd0:    digit = cur_bcd[3:0];
            2'd1:    digit = cur_bcd[7:4];
            default: digit = cur_bcd[11:8];
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_k      = r_k;
        n_vi     = r_vi;
        n_dig    = r_dig;
        n_cmd    = r_cmd;
        o_cmd_rd = 1'b0;
        bvalid   = 1'b0;
        bbyte    = CH_NL;
        blast    = 1'b0;
        bfend    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_rd           = 1'b1;
                    n_cmd              = i_cmd;
                    {n_state, n_phase} = f_start(i_cmd, PH_CUR);
                    n_k                = '0;
                    n_vi               = '0;
                end
            end
            ST_PRE: begin
                if (adv) begin
                    bvalid = 1'b1;
                    case (r_k)
                        3'd0:    bbyte = CH_ESC;
                        3'd1:    bbyte = CH_LBRACK;
                        3'd2:    bbyte = (r_phase == PH_BG) ? CH_FOUR : CH_THREE;
                        3'd3:    bbyte = CH_EIGHT;
                        3'd5:    bbyte = CH_TWO;
                        default: bbyte = CH_SEMI;
                    endcase
                    if (r_k == pre_last) begin
                        n_state = ST_DIG;
                        n_dig   = f_ndig(cur_bcd);
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            ST_DIG: begin
                if (adv) begin
                    bvalid = 1'b1;
                    bbyte  = CH_ZERO + {4'd0, digit};
                    if (r_dig == 2'd0) begin
                        n_state = ST_SEP;
                    end else begin
                        n_dig = r_dig - 2'd1;
                    end
                end
            end
            ST_SEP: begin
                if (adv) begin
                    bvalid = 1'b1;
                    if (r_vi == last_vi) begin
                        bbyte              = (r_phase == PH_CUR) ? CH_H : CH_M;
                        {n_state, n_phase} = f_start(r_cmd, r_phase + 2'd1);
                        n_k                = '0;
                        n_vi               = '0;
                    end else begin
                        bbyte   = CH_SEMI;
                        n_vi    = r_vi + 2'd1;
                        n_state = ST_DIG;
                        n_dig   = f_ndig(nxt_bcd);
                    end
                end
            end
            ST_GLYPH: begin
                if (adv) begin
                    bvalid = 1'b1;
                    case (r_k)
                        3'd0:    bbyte = GLYPH_B0;
                        3'd1:    bbyte = GLYPH_B1;
                        default: bbyte = GLYPH_B2;
                    endcase
                    if (r_k == 3'd2) begin
                        blast   = !r_cmd.nl;
                        n_state = r_cmd.nl ? ST_NL : ST_IDLE;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            ST_NL: begin
                if (adv) begin
                    bvalid  = 1'b1;
                    bbyte   = CH_NL;
                    blast   = 1'b1;
                    bfend   = r_cmd.fend;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_empty        = !r_out_valid;
    assign o_text_byte    = r_out_byte;
    assign o_last_of_item = r_out_last;
    assign o_frame_end    = r_out_fend;

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_phase <= n_phase;
        r_k     <= n_k;
        r_vi    <= n_vi;
        r_dig   <= n_dig;
        if (adv) begin
            r_out_byte <= bbyte;
            r_out_last <= blast;
            r_out_fend <= bfend;
        end
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_out_valid <= bvalid;
            end
        end
    end

`ifndef SYNTHESIS
    a_fend_is_last_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fend) |-> (r_out_last && r_out_byte == CH_NL))
        else $error("frame end not on final newline");
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_rd |-> (r_state == ST_IDLE && !i_cmd_empty))
        else $error("command taken while busy");
`endif
endmodule

// File: hdl/half_block_ansi_delta_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_block_ansi_delta_encoder
// Frame delta encoder that turns pixel pairs into truecolor half-block text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel is queue-like: drive a pixel pair (top = background,
//   bottom = text color) in raster order and raise push; the transaction
//   happens on a clock edge with push high and full low.
//   Output channel is queue-like too: while empty is low the oldest byte sits
//   on o_text_byte with o_last_of_item / o_frame_end; pop takes it.
//   Configuration writes (threshold, columns, rows) take effect in the cycle
//   after i_cfg_wr_en; issue them only while the block is idle.
// Timing:
//   Pixel pairs enter at one per cycle while full is low; the store lookup
//   is registered, then a command enters a four-entry queue. The back end
//   streams one byte per cycle while the receiver pops, plus a load state
//   per command, so a changed pair costs its bytes plus the load state. A
//   pair's first byte passes the lookup register, queue, load state and byte register.
// Reset:
//   Reset is synchronous. After it the shown-frame store is swept to zero,
//   one entry per cycle over all MAX_COLUMNS * MAX_CHAR_ROWS entries (32768
//   by default); full stays high meanwhile. When the receiver stalls, the byte
//   register holds, the command queue fills and full rises.
// ----------------------------------------------------------------------------
module half_block_ansi_delta_encoder
    import hbade_pkg::*;
#(
    parameter int MAX_COLUMNS   = 256,
    parameter int MAX_CHAR_ROWS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_addr,
    input  logic [8:0] i_cfg_wdata,
    // pixel pair input
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_top_red,
    input  logic [7:0] i_top_green,
    input  logic [7:0] i_top_blue,
    input  logic [7:0] i_bottom_red,
    input  logic [7:0] i_bottom_green,
    input  logic [7:0] i_bottom_blue,
    // byte output
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_text_byte,
    output logic       o_last_of_item,
    output logic       o_frame_end
);
    logic [15:0]          r_thr_sq;
    logic [8:0]           r_cols;
    logic [7:0]           r_rows;

    logic                 accept;
    logic                 cmd_wr, cmd_rd, cmd_empty;
    t_cmd                 cmd_in, cmd_out;
    t_front_stat          fstat;
    logic [CMD_CNT_W-1:0] cmd_count;

    // keep room for the pair still in the lookup stage
    assign full = fstat.clearing
               || ((CMD_CNT_W + 1)'(cmd_count) + (CMD_CNT_W + 1)'(fstat.busy)
                   >= (CMD_CNT_W + 1)'(CMD_DEPTH));
    assign accept = push && !full;

    // hold the squared threshold so the compare needs no multiply in line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq <= '0;
            r_cols   <= 9'd256;
            r_rows   <= 8'd128;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_THRESHOLD: r_thr_sq <= 16'(i_cfg_wdata[7:0]) * 16'(i_cfg_wdata[7:0]);
                CFG_COLUMNS:   r_cols   <= i_cfg_wdata;
                CFG_ROWS:      r_rows   <= i_cfg_wdata[7:0];
                default:       ;
            endcase
        end
    end

    hbade_front #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_CHAR_ROWS (MAX_CHAR_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_top       ({i_top_red, i_top_green, i_top_blue}),
        .i_bot       ({i_bottom_red, i_bottom_green, i_bottom_blue}),
        .i_thr_sq    (r_thr_sq),
        .i_cols      (r_cols),
        .i_rows      (r_rows),
        .o_cmd_valid (cmd_wr),
        .o_cmd       (cmd_in),
        .o_stat      (fstat)
    );

    hbade_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_in),
        .i_rd    (cmd_rd),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    hbade_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_empty    (cmd_empty),
        .i_cmd          (cmd_out),
        .o_cmd_rd       (cmd_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_text_byte    (o_text_byte),
        .o_last_of_item (o_last_of_item),
        .o_frame_end    (o_frame_end)
    );
endmodule
